FILE: sv/hrl_pkg.sv
// ----------------------------------------------------------------------------
// hrl_pkg
// shared types, codes and helpers of the hex record loader
// ----------------------------------------------------------------------------
`default_nettype none

package hrl_pkg;

  localparam int DEF_RECORD_BYTES = 37;
  localparam int DEF_INDEX_BITS   = 16;

  localparam logic [7:0] COLON = 8'h3A;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_CSUM = 2'd2;
  localparam logic [1:0] KIND_OVFL = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COLLECT,
    PH_EMIT,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    V_NONE,
    V_GOOD,
    V_BAD
  } verdict_t;

  // address width of a store of the given depth, at least one bit
  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // ascii hex digit to nibble, anything else gives zero
  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] nib;
    nib = 4'd0;
    case (ch) inside
      [8'h30:8'h39]: nib = 4'(ch - 8'h30);
      [8'h41:8'h46]: nib = 4'(ch - 8'h41 + 8'd10);
      [8'h61:8'h66]: nib = 4'(ch - 8'h61 + 8'd10);
      default:       nib = 4'd0;
    endcase
    return nib;
  endfunction

endpackage

`default_nettype wire

FILE: sv/hrl_ram.sv
// ----------------------------------------------------------------------------
// hrl_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [hrl_pkg::addr_bits(DEPTH)-1:0]   wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [hrl_pkg::addr_bits(DEPTH)-1:0]   rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: sv/hex_record_loader.sv
// ----------------------------------------------------------------------------
// hex_record_loader
// streaming loader for fixed-length intel hex records
// a record is taken at one character per cycle while char_stall is low; done
// and checksum items appear in the cycle after the item that causes them
// a colon that releases a good record starts a burst of RECORD_BYTES-5 bytes,
// fewer if the buffer fills; each byte is read from the store, then loaded
// into the output register, and input is stalled for the whole burst;
// receiver stalls stretch the burst
// input is also held off while a result waits in the output register
// synchronous active-high reset clears all control state; buffer_size resets
// to 2**INDEX_BITS; the record store holds no reset value and is never read
// before a full record has filled it
// ----------------------------------------------------------------------------
`default_nettype none

module hex_record_loader #(
  parameter int RECORD_BYTES = hrl_pkg::DEF_RECORD_BYTES,
  parameter int INDEX_BITS   = hrl_pkg::DEF_INDEX_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_write,
  input  wire logic [INDEX_BITS:0]   cfg_data,
  // character items
  input  wire logic                  char_valid,
  output logic                       char_stall,
  input  wire logic [7:0]            char_in,
  input  wire logic                  end_of_file,
  // result items
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [1:0]                 kind,
  output logic [INDEX_BITS:0]        index,
  output logic [7:0]                 data_byte,
  output logic [15:0]                line_number,
  output logic                       last
);

  // geometry of one record
  localparam int DATA_BYTES = RECORD_BYTES - 5;
  localparam int ADDR_BITS  = hrl_pkg::addr_bits(DATA_BYTES);
  localparam int CNT_BITS   = $clog2(2 * RECORD_BYTES + 1);
  localparam int IDX_W      = INDEX_BITS + 1;

  localparam logic [CNT_BITS-1:0]  CNT_LAST  = CNT_BITS'(2 * RECORD_BYTES - 1);
  localparam logic [CNT_BITS-2:0]  SUM_BYTES = (CNT_BITS-1)'(RECORD_BYTES - 1);
  localparam logic [CNT_BITS-2:0]  FIRST_DAT = (CNT_BITS-1)'(4);
  localparam logic [ADDR_BITS-1:0] ADDR_LAST = ADDR_BITS'(DATA_BYTES - 1);
  localparam logic [IDX_W-1:0]     BUF_RESET = IDX_W'(1) << INDEX_BITS;

  // control registers
  hrl_pkg::phase_t   phase, phase_next;
  hrl_pkg::verdict_t verdict, verdict_next;
  logic [CNT_BITS-1:0]  char_count, char_count_next;
  logic [3:0]           high_nibble, high_nibble_next;
  logic [7:0]           running_sum, running_sum_next;
  logic [IDX_W-1:0]     write_pointer, write_pointer_next;
  logic [15:0]          record_counter, record_counter_next;
  logic [ADDR_BITS-1:0] emit_idx, emit_idx_next;
  logic                 rd_ok, rd_ok_next;
  logic [IDX_W-1:0]     buffer_size;

  // output register next values
  logic                 out_load;
  logic [1:0]           kind_next;
  logic [IDX_W-1:0]     index_next;
  logic [7:0]           data_byte_next;
  logic [15:0]          line_number_next;
  logic                 last_next;

  // record store port
  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_wr_addr;
  logic [7:0]           ram_rd_data;

  // decode of the current character
  logic                 out_free;
  logic                 accept;
  logic [3:0]           nib;
  logic [7:0]           pair_byte;
  logic [CNT_BITS-2:0]  byte_pos;
  logic                 wp_fits;

  assign out_free   = !result_valid || !result_stall;
  // no items taken during a data burst or while a result is still waiting
  assign char_stall = (phase == hrl_pkg::PH_EMIT) || !out_free;
  assign accept     = char_valid && !char_stall;

  assign nib       = hrl_pkg::hex_value(char_in);
  assign pair_byte = {high_nibble, nib};
  assign byte_pos  = char_count[CNT_BITS-1:1];
  assign wp_fits   = write_pointer < buffer_size;

  // data bytes of the record land at store entries from zero
  assign ram_wr_addr = ADDR_BITS'(byte_pos - FIRST_DAT);
  assign ram_we      = accept && !end_of_file && (phase == hrl_pkg::PH_COLLECT)
                       && char_count[0] && (byte_pos < SUM_BYTES)
                       && (byte_pos >= FIRST_DAT);

  hrl_ram #(
    .WIDTH (8),
    .DEPTH (DATA_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (pair_byte),
    .rd_addr (emit_idx),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    phase_next = phase;
    case (phase)
      hrl_pkg::PH_IDLE: begin
        if (accept) begin
          if (end_of_file) begin
            phase_next = hrl_pkg::PH_STOP;
          end else if (char_in == hrl_pkg::COLON) begin
            case (verdict)
              hrl_pkg::V_GOOD: phase_next = hrl_pkg::PH_EMIT;
              hrl_pkg::V_BAD:  phase_next = hrl_pkg::PH_STOP;
              default:         phase_next = hrl_pkg::PH_COLLECT;
            endcase
          end
        end
      end
      hrl_pkg::PH_COLLECT: begin
        if (accept) begin
          if (end_of_file) begin
            phase_next = hrl_pkg::PH_STOP;
          end else if (char_count == CNT_LAST) begin
            phase_next = hrl_pkg::PH_IDLE;
          end
        end
      end
      hrl_pkg::PH_EMIT: begin
        if (rd_ok && out_free) begin
          if (!wp_fits) begin
            phase_next = hrl_pkg::PH_STOP;
          end else if (emit_idx == ADDR_LAST) begin
            phase_next = hrl_pkg::PH_COLLECT;
          end
        end
      end
      default: phase_next = phase;
    endcase
  end

  // datapath and result generation
  always_comb begin
    char_count_next     = char_count;
    high_nibble_next    = high_nibble;
    running_sum_next    = running_sum;
    verdict_next        = verdict;
    write_pointer_next  = write_pointer;
    record_counter_next = record_counter;
    emit_idx_next       = emit_idx;
    rd_ok_next          = rd_ok;
    out_load            = 1'b0;
    kind_next           = hrl_pkg::KIND_DATA;
    index_next          = '0;
    data_byte_next      = 8'd0;
    line_number_next    = 16'd0;
    last_next           = 1'b0;

    case (phase)
      hrl_pkg::PH_IDLE,
      hrl_pkg::PH_COLLECT: begin
        if (accept && end_of_file) begin
          // done carries the byte total
          out_load   = 1'b1;
          kind_next  = hrl_pkg::KIND_DONE;
          index_next = write_pointer;
          last_next  = 1'b1;
        end else if (accept && (phase == hrl_pkg::PH_COLLECT)) begin
          if (!char_count[0]) begin
            high_nibble_next = nib;
          end else if (byte_pos < SUM_BYTES) begin
            running_sum_next = running_sum + pair_byte;
          end else begin
            verdict_next = (8'(8'd0 - running_sum) == pair_byte) ?
                           hrl_pkg::V_GOOD : hrl_pkg::V_BAD;
          end
          char_count_next = char_count + CNT_BITS'(1);
        end else if (accept && (char_in == hrl_pkg::COLON)) begin
          // colon: act on the held verdict, open a new record
          if (verdict == hrl_pkg::V_BAD) begin
            out_load         = 1'b1;
            kind_next        = hrl_pkg::KIND_CSUM;
            line_number_next = record_counter;
            last_next        = 1'b1;
          end
          verdict_next        = hrl_pkg::V_NONE;
          record_counter_next = record_counter + 16'd1;
          char_count_next     = '0;
          high_nibble_next    = 4'd0;
          running_sum_next    = 8'd0;
          emit_idx_next       = '0;
          rd_ok_next          = 1'b0;
        end
      end
      hrl_pkg::PH_EMIT: begin
        if (rd_ok && out_free) begin
          out_load = 1'b1;
          rd_ok_next = 1'b0;
          emit_idx_next = emit_idx + ADDR_BITS'(1);
          if (wp_fits) begin
            kind_next          = hrl_pkg::KIND_DATA;
            index_next         = write_pointer;
            data_byte_next     = ram_rd_data;
            last_next          = (emit_idx == ADDR_LAST);
            write_pointer_next = write_pointer + IDX_W'(1);
          end else begin
            kind_next = hrl_pkg::KIND_OVFL;
            last_next = 1'b1;
          end
        end else begin
          // store read of emit_idx completes at this edge
          rd_ok_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= hrl_pkg::PH_IDLE;
      verdict        <= hrl_pkg::V_NONE;
      char_count     <= '0;
      high_nibble    <= 4'd0;
      running_sum    <= 8'd0;
      write_pointer  <= '0;
      record_counter <= 16'd0;
      emit_idx       <= '0;
      rd_ok          <= 1'b0;
      buffer_size    <= BUF_RESET;
      result_valid   <= 1'b0;
    end else begin
      phase          <= phase_next;
      verdict        <= verdict_next;
      char_count     <= char_count_next;
      high_nibble    <= high_nibble_next;
      running_sum    <= running_sum_next;
      write_pointer  <= write_pointer_next;
      record_counter <= record_counter_next;
      emit_idx       <= emit_idx_next;
      rd_ok          <= rd_ok_next;
      if (cfg_write) begin
        buffer_size <= cfg_data;
      end
      result_valid   <= out_load || (result_valid && result_stall);
    end
  end

  // output payload, loaded only when the register is free
  always_ff @(posedge clk) begin
    if (out_load) begin
      kind        <= kind_next;
      index       <= index_next;
      data_byte   <= data_byte_next;
      line_number <= line_number_next;
      last        <= last_next;
    end
  end

  // a data item never points past the buffer end
  a_data_in_buffer: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == hrl_pkg::KIND_DATA) |-> index < buffer_size)
    else $error("data item beyond buffer size");

  // a status item leaves the block stopped
  a_status_stops: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind != hrl_pkg::KIND_DATA) |-> phase == hrl_pkg::PH_STOP)
    else $error("status item without stop");

  // the last data byte of a burst closes the burst
  a_burst_closed: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == hrl_pkg::KIND_DATA) && last |-> phase != hrl_pkg::PH_EMIT)
    else $error("burst still running after its last byte");

  // stop holds until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == hrl_pkg::PH_STOP |=> phase == hrl_pkg::PH_STOP)
    else $error("left stop without reset");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hex record loader: streams fixed-length hex
// records with random content, random sender bursts and receiver stalls,
// predicts every data, done and error item and checks them in order
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int REC_BYTES      = hrl_pkg::DEF_RECORD_BYTES;
  localparam int REC_CHARS      = 2 * REC_BYTES;
  localparam int DATA_COUNT     = REC_BYTES - 5;
  localparam int IDX_W          = hrl_pkg::DEF_INDEX_BITS + 1;
  localparam int DIRECTED_ROWS  = 25;
  localparam int PREFIX_ROW     = 7;    // first row that belongs to record one
  localparam int PREFIX_CHARS   = 18;   // record one characters fixed by the table
  localparam int SETTLE_CYCLES  = 8;    // margin before a register write
  localparam int END_CYCLES     = 80;   // one full data burst and then some
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] index;
    logic [7:0]       data_byte;
    logic [15:0]      line_number;
    logic             last;
  } result_t;

  // one row of the opening table; no_result marks rows known to give nothing
  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
    logic       no_result;
  } stim_row_t;

  // how the run closes, one per seed
  typedef enum int {
    END_CSUM,
    END_OVFL,
    END_EOF_HELD,
    END_EOF_PARTIAL
  } ending_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             cfg_write    = 1'b0;
  logic [IDX_W-1:0] cfg_data     = '0;
  logic             char_valid   = 1'b0;
  logic [7:0]       char_in      = 8'h00;
  logic             end_of_file  = 1'b0;
  logic             result_stall = 1'b0;

  logic             char_stall;
  logic             result_valid;
  logic [1:0]       kind;
  logic [IDX_W-1:0] index;
  logic [7:0]       data_byte;
  logic [15:0]      line_number;
  logic             last;

  always #(CLK_PERIOD / 2) clk = ~clk;

  hex_record_loader u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_in      (char_in),
    .end_of_file  (end_of_file),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .index        (index),
    .data_byte    (data_byte),
    .line_number  (line_number),
    .last         (last)
  );

  // ---------------------------------------------------------------------------
  // loader predictor state, mirrors the block after reset
  // ---------------------------------------------------------------------------
  hrl_pkg::phase_t   load_phase  = hrl_pkg::PH_IDLE;
  logic [6:0]        char_pos    = '0;
  logic [3:0]        hi_digit    = '0;
  logic [7:0]        record_bytes [0:DATA_COUNT-1];
  logic [7:0]        byte_sum    = '0;
  hrl_pkg::verdict_t held        = hrl_pkg::V_NONE;
  logic [IDX_W-1:0]  write_ptr   = '0;
  logic [15:0]       record_num  = '0;
  logic [IDX_W-1:0]  buffer_room = 17'h10000;

  result_t          out_buf [0:DATA_COUNT-1];   // items caused by one character
  result_t          awaited_results [$];        // predicted, not yet seen

  logic [7:0]       rec_chars [0:REC_CHARS-1];  // record being streamed
  stim_row_t        directed_rows [0:DIRECTED_ROWS-1];

  int               burst_left    = 0;
  int               stall_run     = 0;
  bit               stalling      = 1'b0;
  int               idle_cycles   = 0;
  int               mismatch_count = 0;

  // ascii digit to nibble, anything that is not a hex digit counts as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 4'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return 4'(c - CH_UA + 8'd10);
    if (c >= CH_LA && c <= CH_LF) return 4'(c - CH_LA + 8'd10);
    return 4'd0;
  endfunction

  // advance the predictor by one accepted item and queue what it causes
  function automatic void step_loader(input logic [7:0] ch, input logic eof,
                                      input bit keep);
    logic [3:0] nib;
    logic [7:0] pair;
    result_t    r;
    int         pos;
    int         n;
    int         i;
    n = 0;
    if (load_phase == hrl_pkg::PH_STOP) return;
    if (eof) begin
      // held verdict and any partial record are dropped
      out_buf[0] = {hrl_pkg::KIND_DONE, write_ptr, 8'h00, 16'h0000, 1'b0};
      n = 1;
      load_phase = hrl_pkg::PH_STOP;
    end else if (load_phase == hrl_pkg::PH_COLLECT) begin
      nib = nibble_of(ch);
      if (!char_pos[0]) begin
        hi_digit = nib;
      end else begin
        pair = {hi_digit, nib};
        pos  = int'(char_pos >> 1);
        if (pos < REC_BYTES - 1) begin
          byte_sum = byte_sum + pair;
          if (pos >= 4) record_bytes[pos-4] = pair;
        end else begin
          held = (8'(8'd0 - byte_sum) == pair) ? hrl_pkg::V_GOOD : hrl_pkg::V_BAD;
        end
      end
      char_pos = char_pos + 7'd1;
      if (char_pos >= REC_CHARS) load_phase = hrl_pkg::PH_IDLE;
    end else if (ch == hrl_pkg::COLON) begin
      // a new colon acts on the verdict of the record before it
      if (held == hrl_pkg::V_GOOD) begin
        for (i = 0; i < DATA_COUNT; i++) begin
          if (write_ptr < buffer_room) begin
            out_buf[n] = {hrl_pkg::KIND_DATA, write_ptr, record_bytes[i], 16'h0000, 1'b0};
            n++;
            write_ptr = write_ptr + 1'b1;
          end else begin
            out_buf[n] = {hrl_pkg::KIND_OVFL, {IDX_W{1'b0}}, 8'h00, 16'h0000, 1'b0};
            n++;
            load_phase = hrl_pkg::PH_STOP;
            break;
          end
        end
      end else if (held == hrl_pkg::V_BAD) begin
        out_buf[0] = {hrl_pkg::KIND_CSUM, {IDX_W{1'b0}}, 8'h00, record_num, 1'b0};
        n = 1;
        load_phase = hrl_pkg::PH_STOP;
      end
      held       = hrl_pkg::V_NONE;
      record_num = record_num + 16'd1;
      if (load_phase != hrl_pkg::PH_STOP) begin
        load_phase = hrl_pkg::PH_COLLECT;
        char_pos   = '0;
        hi_digit   = '0;
        byte_sum   = '0;
      end
    end
    if (keep) begin
      for (i = 0; i < n; i++) begin
        r      = out_buf[i];
        r.last = (i == n - 1);
        awaited_results.push_back(r);
      end
    end
  endfunction

  // character for one nibble: either case, and now and then a non-hex
  // character or a colon where the nibble is zero
  function automatic logic [7:0] digit_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib == 4'd0 && $urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        c = hrl_pkg::COLON;
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (nibble_of(c) != 4'd0 || c == CH_0);
      end
    end else if (nib < 4'd10) begin
      c = CH_0 + 8'(nib);
    end else if ($urandom_range(0, 1) == 1) begin
      c = CH_UA + 8'(nib) - 8'd10;
    end else begin
      c = CH_LA + 8'(nib) - 8'd10;
    end
    return c;
  endfunction

  // fill rec_chars past the first fixed_n characters and close it with a
  // checksum that is right when good is set and wrong otherwise
  task automatic build_record(input int fixed_n, input bit good);
    logic [7:0] val;
    logic [7:0] total;
    int         b;
    total = 8'h00;
    for (b = 0; b < REC_BYTES - 1; b++) begin
      if (2 * b < fixed_n) begin
        val = {nibble_of(rec_chars[2*b]), nibble_of(rec_chars[2*b+1])};
      end else begin
        case ($urandom_range(0, 7))
          0:       val = 8'h00;
          1:       val = 8'hFF;
          default: val = 8'($urandom_range(0, 255));
        endcase
        rec_chars[2*b]   = digit_char(val[7:4]);
        rec_chars[2*b+1] = digit_char(val[3:0]);
      end
      total = total + val;
    end
    val = 8'd0 - total;
    if (!good) val = val + 8'($urandom_range(1, 255));
    rec_chars[REC_CHARS-2] = digit_char(val[7:4]);
    rec_chars[REC_CHARS-1] = digit_char(val[3:0]);
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts of random length with random gaps, payload held while
  // stalled, driven at the falling edge and accepted at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] ch, input logic eof, input bit keep);
    @(negedge clk);
    if (burst_left == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 16);
    end
    burst_left--;
    char_in     <= ch;
    end_of_file <= eof;
    char_valid  <= 1'b1;
    do @(posedge clk);
    while (char_stall);
    step_loader(ch, eof, keep);
  endtask

  // characters outside a record, never a colon
  task automatic send_noise(input int count);
    logic [7:0] c;
    int         i;
    for (i = 0; i < count; i++) begin
      do c = 8'($urandom_range(0, 255));
      while (c == hrl_pkg::COLON);
      send_item(c, 1'b0, 1'b1);
    end
  endtask

  task automatic send_record(input int from, input int upto);
    int i;
    for (i = from; i < upto; i++) send_item(rec_chars[i], 1'b0, 1'b1);
  endtask

  // hold the sender until every predicted item is out, then let it settle
  task automatic drain_results();
    @(negedge clk);
    char_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, entered at a falling edge with the block idle
  task automatic set_buffer_size(input logic [IDX_W-1:0] size);
    cfg_write   <= 1'b1;
    cfg_data    <= size;
    buffer_room  = size;
    @(negedge clk);
    cfg_write   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: alternating runs of stall and open, with long open stretches
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stalling = !stalling;
      if (stalling) begin
        stall_run = $urandom_range(1, 6);
      end else begin
        stall_run = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      end
    end
    stall_run--;
    result_stall <= stalling;
  end

  // ---------------------------------------------------------------------------
  // result checker: each accepted item against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected item: kind %0d index %0d byte %02h line %0d last %0b",
                   kind, index, data_byte, line_number, last);
      end else begin
        want = awaited_results.pop_front();
        if (kind !== want.kind || index !== want.index ||
            data_byte !== want.data_byte || line_number !== want.line_number ||
            last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch: expected kind %0d index %0d byte %02h line %0d last %0b",
                     want.kind, want.index, want.data_byte, want.line_number,
                     want.last);
            $display("          got      kind %0d index %0d byte %02h line %0d last %0b",
                     kind, index, data_byte, line_number, last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any item moving on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    ending_t          ending;
    logic [IDX_W-1:0] room;
    int               i;
    int               r;

    // noise and a colon outside a record, then the head of record one with
    // digits at both ends of the range, both cases and non-hex characters
    directed_rows = '{
      {8'h00, 1'b0, 1'b1},   // lowest character, skipped
      {8'hFF, 1'b0, 1'b1},   // highest character, skipped
      {8'h46, 1'b0, 1'b1},   // hex digit outside a record
      {8'h30, 1'b0, 1'b1},
      {8'h3B, 1'b0, 1'b1},   // neighbour of the colon
      {8'hBA, 1'b0, 1'b1},   // colon pattern with bit 7 set
      {8'h3A, 1'b0, 1'b1},   // first colon, nothing held yet
      {8'h32, 1'b0, 1'b0},   // byte count 20
      {8'h30, 1'b0, 1'b0},
      {8'h46, 1'b0, 1'b0},   // address ff00
      {8'h46, 1'b0, 1'b0},
      {8'h30, 1'b0, 1'b0},
      {8'h30, 1'b0, 1'b0},
      {8'h30, 1'b0, 1'b0},   // record type 00
      {8'h30, 1'b0, 1'b0},
      {8'h66, 1'b0, 1'b0},   // data ff in lower case
      {8'h66, 1'b0, 1'b0},
      {8'h41, 1'b0, 1'b0},   // data aa in mixed case
      {8'h61, 1'b0, 1'b0},
      {8'h3A, 1'b0, 1'b0},   // colon inside a record reads as zero
      {8'h67, 1'b0, 1'b0},   // so does a letter past f
      {8'h39, 1'b0, 1'b0},   // data 90
      {8'h30, 1'b0, 1'b0},
      {8'h80, 1'b0, 1'b0},   // non-hex high digit, data 07
      {8'h37, 1'b0, 1'b0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // top of the range, same as the value after reset
    set_buffer_size(17'h10000);

    for (i = 0; i < DIRECTED_ROWS; i++)
      send_item(directed_rows[i].ch, directed_rows[i].eof, !directed_rows[i].no_result);

    // finish record one around the fixed head
    for (i = 0; i < PREFIX_CHARS; i++) rec_chars[i] = directed_rows[PREFIX_ROW + i].ch;
    build_record(PREFIX_CHARS, 1'b1);
    send_record(PREFIX_CHARS, REC_CHARS);

    // records two to four, each colon releasing the record before it
    for (r = 2; r <= 4; r++) begin
      send_noise($urandom_range(0, 5));
      drain_results();
      case (r)
        2:       room = 17'd65535;
        3:       room = IDX_W'($urandom_range(65535, int'(write_ptr) + DATA_COUNT));
        default: room = write_ptr + IDX_W'(DATA_COUNT);   // fills the buffer exactly
      endcase
      set_buffer_size(room);
      send_item(hrl_pkg::COLON, 1'b0, 1'b1);
      build_record(0, 1'b1);
      send_record(0, REC_CHARS);
    end

    // colon five writes record four, then the run closes one of four ways
    send_noise($urandom_range(0, 5));
    drain_results();
    set_buffer_size(17'h10000);
    send_item(hrl_pkg::COLON, 1'b0, 1'b1);
    ending = ending_t'($urandom_range(0, 3));

    if (ending == END_EOF_PARTIAL) begin
      // end of file part way through a record
      drain_results();
      set_buffer_size('0);
      build_record(0, 1'b1);
      send_record(0, $urandom_range(0, REC_CHARS - 1));
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else begin
      build_record(0, (ending == END_OVFL) ||
                      (ending == END_EOF_HELD && $urandom_range(0, 1) == 1));
      send_record(0, REC_CHARS);
      send_noise($urandom_range(0, 5));
      drain_results();
      room = '0;
      if (ending == END_OVFL) begin
        // empty buffer, buffer already full, or room for part of the record
        case ($urandom_range(0, 2))
          0:       room = '0;
          1:       room = write_ptr;
          default: room = write_ptr + IDX_W'($urandom_range(1, DATA_COUNT - 1));
        endcase
      end
      set_buffer_size(room);
      if (ending == END_EOF_HELD) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      else send_item(hrl_pkg::COLON, 1'b0, 1'b1);
    end

    // stopped: nothing may come out of these
    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    for (i = 0; i < 7; i++) begin
      case ($urandom_range(0, 2))
        0:       send_item(hrl_pkg::COLON, 1'b0, 1'b1);
        1:       send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        default: send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      endcase
    end

    @(negedge clk);
    char_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/hrl_pkg.sv
sv/hrl_ram.sv
sv/hex_record_loader.sv
sim/tb_top.sv
